@@ rtl/sdrrip_pkg.sv @@
// Package for the SHiP-DRRIP replacement core: sizes, field types, set-row layout,
// controller states and the BRRIP insertion helper.
// No dependencies; compile first.
package sdrrip_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int NUM_WAYS    = 16;
  localparam int SIG_W       = 14;
  localparam int RRPV_W      = 2;
  localparam int SEL_W       = 10;
  localparam int DUEL_PERIOD = 64;
  localparam int BRRIP_BITS  = 5;
  localparam int PC_SHIFT    = 2;
  localparam int ADDR_SHIFT  = 12;

  localparam int SET_IN_W = 11;
  localparam int WAY_IN_W = 4;
  localparam int PC_W     = 64;
  localparam int BADDR_W  = 64;
  localparam int INS_W    = 2;

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int DUEL_W    = $clog2(DUEL_PERIOD);
  localparam int SIG_COUNT = 1 << SIG_W;
  localparam int CLEAR_LEN = (SIG_COUNT > NUM_SETS) ? SIG_COUNT : NUM_SETS;
  localparam int CLR_W     = $clog2(CLEAR_LEN);
  localparam int CTR_W     = 2;

  typedef logic [RRPV_W-1:0] rrpv_t;
  typedef logic [SIG_W-1:0]  sig_t;
  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [SET_W-1:0]  set_t;
  typedef logic [CTR_W-1:0]  ctr_t;
  typedef logic [SEL_W-1:0]  sel_t;
  typedef logic [CLR_W-1:0]  clr_t;

  localparam rrpv_t RRPV_TOP  = '1;
  localparam rrpv_t RRPV_MID  = RRPV_TOP - rrpv_t'(1);
  localparam ctr_t  CTR_TOP   = '1;
  localparam ctr_t  CTR_START = ctr_t'(1);
  localparam ctr_t  CTR_HALF  = CTR_TOP >> 1;
  localparam sel_t  SEL_TOP   = '1;
  localparam sel_t  SEL_START = SEL_TOP >> 1;

  typedef struct packed {
    rrpv_t [NUM_WAYS-1:0] rrpv;
    sig_t  [NUM_WAYS-1:0] sig;
  } set_row_t;

  localparam set_row_t ROW_RESET = '{rrpv: {NUM_WAYS{RRPV_MID}}, sig: '0};

  typedef struct packed {
    way_t                 way;
    rrpv_t [NUM_WAYS-1:0] aged;
  } victim_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETRD,
    ST_CTR1,
    ST_CTR2
  } state_t;

  function automatic rrpv_t brrip_value(sig_t s);
    return (s[BRRIP_BITS-1:0] == '0) ? '0 : RRPV_TOP;
  endfunction

endpackage

@@ rtl/sdrrip_ifs.sv @@
// Valid/ready channel interfaces for access requests and replacement results.
// Depends on sdrrip_pkg.
interface sdrrip_req_if;
  import sdrrip_pkg::*;
  logic                valid;
  logic                ready;
  logic [SET_IN_W-1:0] set_index;
  logic                hit;
  logic [WAY_IN_W-1:0] hit_way;
  logic [PC_W-1:0]     pc;
  logic [BADDR_W-1:0]  block_addr;

  modport source (output valid, set_index, hit, hit_way, pc, block_addr, input ready);
  modport sink   (input valid, set_index, hit, hit_way, pc, block_addr, output ready);
endinterface

interface sdrrip_rsp_if;
  import sdrrip_pkg::*;
  logic                valid;
  logic                ready;
  logic [WAY_IN_W-1:0] chosen_way;
  logic                was_miss;
  logic [INS_W-1:0]    insert_rrpv;

  modport source (output valid, chosen_way, was_miss, insert_rrpv, input ready);
  modport sink   (input valid, chosen_way, was_miss, insert_rrpv, output ready);
endinterface

@@ rtl/sdrrip_ram.sv @@
// Generic simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module sdrrip_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/sdrrip_victim.sv @@
// Victim search over one set row: age all ways until the top RRPV is reached
// and pick the lowest way at the top. Depends on sdrrip_pkg.
module sdrrip_victim (
  input  sdrrip_pkg::rrpv_t [sdrrip_pkg::NUM_WAYS-1:0] rrpv,
  output sdrrip_pkg::victim_t                          vic
);
  import sdrrip_pkg::*;

  logic [(1 << RRPV_W)-1:0] present;
  rrpv_t                    top;
  rrpv_t                    lift;
  logic                     found;

  always_comb begin
    present = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      present[rrpv[w]] = 1'b1;
    end
    top = '0;
    for (int v = 0; v < (1 << RRPV_W); v++) begin
      if (present[v]) begin
        top = rrpv_t'(v);
      end
    end
    lift = RRPV_TOP - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      vic.aged[w] = rrpv[w] + lift;
    end
    vic.way = '0;
    found   = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && rrpv[w] == top) begin
        vic.way = way_t'(w);
        found   = 1'b1;
      end
    end
  end

endmodule

@@ rtl/ship_drrip_replacement_core.sv @@
// SHiP-DRRIP replacement core: set-row RAM, reuse-counter RAM, victim search and
// the access sequencer. Depends on sdrrip_pkg, sdrrip_ifs, sdrrip_ram, sdrrip_victim.
//
//   channel | dir | payload                                        | handshake
//   req     | in  | set_index, hit, hit_way, pc, block_addr        | valid/ready
//   rsp     | out | chosen_way, was_miss, insert_rrpv              | valid/ready
//
// A hit runs set-row read and counter read/update, a miss adds a second counter
// read before the row write-back; the single read port of each RAM sets these steps,
// and a new request is taken only when the sequencer is back in idle.
// After rst a clearing pass writes both RAMs; req.ready stays low.
// A finished result sits in the output register; the next request is taken while it
// waits, and a later result holds in the sequencer until the register frees up.
module ship_drrip_replacement_core (
  input logic        clk,
  input logic        rst,
  sdrrip_req_if.sink   req,
  sdrrip_rsp_if.source rsp
);
  import sdrrip_pkg::*;

  state_t   st;
  state_t   st_next;
  clr_t     clr_cnt;
  sel_t     sel;
  logic     out_valid;

  set_t     cur_set;
  logic     cur_hit;
  way_t     cur_way;
  sig_t     new_sig;
  logic     srrip_lead;
  logic     brrip_lead;
  rrpv_t [NUM_WAYS-1:0] rrpv_row;
  sig_t  [NUM_WAYS-1:0] sig_row;
  sig_t     old_sig;
  logic     fwd_hit;
  ctr_t     fwd_val;
  way_t     out_way;
  logic     out_miss;
  rrpv_t    out_ins;

  logic     accept;
  logic     out_free;
  logic     out_load;
  logic     clr_in_sets;

  logic     set_we;
  set_t     set_waddr;
  set_row_t set_wdata;
  logic     set_re;
  set_row_t set_rdata;

  logic     ctr_we;
  sig_t     ctr_waddr;
  ctr_t     ctr_wdata;
  logic     ctr_re;
  sig_t     ctr_raddr;
  ctr_t     ctr_rdata;

  victim_t  vic;
  rrpv_t [NUM_WAYS-1:0] hit_rrpv;
  ctr_t     ctr_inc;
  ctr_t     ctr_dec;
  ctr_t     ctr_new;
  rrpv_t    ins;
  set_row_t fin_row;
  set_t     req_set;

  sdrrip_ram #(.AW(SET_W), .DW($bits(set_row_t))) u_set_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (set_waddr),
    .wdata (set_wdata),
    .re    (set_re),
    .raddr (req_set),
    .rdata (set_rdata)
  );

  sdrrip_ram #(.AW(SIG_W), .DW(CTR_W)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .re    (ctr_re),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  sdrrip_victim u_victim (
    .rrpv (set_rdata.rrpv),
    .vic  (vic)
  );

  assign req_set     = req.set_index[SET_W-1:0];
  assign accept      = req.valid && req.ready;
  assign out_free    = !out_valid || rsp.ready;
  assign clr_in_sets = {1'b0, clr_cnt} < (CLR_W + 1)'(NUM_SETS);

  always_comb begin
    hit_rrpv          = set_rdata.rrpv;
    hit_rrpv[cur_way] = '0;
    ctr_inc = (ctr_rdata == CTR_TOP) ? ctr_rdata : ctr_rdata + ctr_t'(1);
    ctr_dec = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - ctr_t'(1);
    ctr_new = fwd_hit ? fwd_val : ctr_rdata;
    priority if (ctr_new > CTR_HALF) begin
      ins = '0;
    end else if (srrip_lead) begin
      ins = RRPV_MID;
    end else if (brrip_lead) begin
      ins = brrip_value(new_sig);
    end else if (sel >= SEL_START) begin
      ins = brrip_value(new_sig);
    end else begin
      ins = RRPV_MID;
    end
    fin_row.rrpv          = rrpv_row;
    fin_row.sig           = sig_row;
    fin_row.rrpv[cur_way] = ins;
    fin_row.sig[cur_way]  = new_sig;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR: if (clr_cnt == clr_t'(CLEAR_LEN - 1)) st_next = ST_IDLE;
      ST_IDLE:  if (req.valid) st_next = ST_SETRD;
      ST_SETRD: st_next = ST_CTR1;
      ST_CTR1: begin
        if (!cur_hit) begin
          st_next = ST_CTR2;
        end else if (out_free) begin
          st_next = ST_IDLE;
        end
      end
      ST_CTR2:  if (out_free) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    set_re    = 1'b0;
    set_we    = 1'b0;
    set_waddr = cur_set;
    set_wdata = fin_row;
    ctr_re    = 1'b0;
    ctr_raddr = new_sig;
    ctr_we    = 1'b0;
    ctr_waddr = old_sig;
    ctr_wdata = ctr_dec;
    out_load  = 1'b0;
    unique case (st)
      ST_CLEAR: begin
        set_we    = clr_in_sets;
        set_waddr = clr_cnt[SET_W-1:0];
        set_wdata = ROW_RESET;
        ctr_we    = 1'b1;
        ctr_waddr = clr_cnt[SIG_W-1:0];
        ctr_wdata = CTR_START;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        set_re    = req.valid;
      end
      ST_SETRD: begin
        ctr_re = 1'b1;
        if (cur_hit) begin
          set_we         = 1'b1;
          set_wdata.rrpv = hit_rrpv;
          set_wdata.sig  = set_rdata.sig;
          ctr_raddr      = set_rdata.sig[cur_way];
        end else begin
          ctr_raddr = set_rdata.sig[vic.way];
        end
      end
      ST_CTR1: begin
        ctr_we = 1'b1;
        if (cur_hit) begin
          ctr_wdata = ctr_inc;
          out_load  = out_free;
        end else begin
          ctr_re = 1'b1;
        end
      end
      ST_CTR2: begin
        set_we   = out_free;
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_cnt   <= '0;
      sel       <= SEL_START;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_CLEAR) begin
        clr_cnt <= clr_cnt + clr_t'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (st == ST_CTR1 && !cur_hit) begin
        if (srrip_lead && sel != SEL_TOP) begin
          sel <= sel + sel_t'(1);
        end else if (brrip_lead && sel != '0) begin
          sel <= sel - sel_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_set    <= req_set;
      cur_hit    <= req.hit;
      cur_way    <= req.hit_way[WAY_W-1:0];
      new_sig    <= req.pc[PC_SHIFT +: SIG_W] ^ req.block_addr[ADDR_SHIFT +: SIG_W];
      srrip_lead <= req_set[DUEL_W-1:0] == DUEL_W'(0);
      brrip_lead <= req_set[DUEL_W-1:0] == DUEL_W'(1);
    end
    if (st == ST_SETRD) begin
      sig_row <= set_rdata.sig;
      if (cur_hit) begin
        rrpv_row <= hit_rrpv;
        old_sig  <= set_rdata.sig[cur_way];
      end else begin
        rrpv_row <= vic.aged;
        old_sig  <= set_rdata.sig[vic.way];
        cur_way  <= vic.way;
      end
    end
    if (st == ST_CTR1) begin
      fwd_hit <= new_sig == old_sig;
      fwd_val <= ctr_dec;
    end
    if (out_load) begin
      out_way  <= cur_way;
      out_miss <= !cur_hit;
      out_ins  <= cur_hit ? '0 : ins;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.chosen_way  = WAY_IN_W'(out_way);
  assign rsp.was_miss    = out_miss;
  assign rsp.insert_rrpv = INS_W'(out_ins);

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || rsp.ready))
    else $error("result loaded over a pending result");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(set_re && set_we))
    else $error("set row read and write in the same cycle");

  a_sel_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    !$stable(sel) |-> ($past(st) == ST_CTR1 && !$past(cur_hit)))
    else $error("selector moved outside a miss update");

  a_hit_inserts_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && cur_hit) |=> (out_ins == '0 && !out_miss))
    else $error("hit result carries a nonzero insertion");

endmodule

@@ tb/ship_drrip_replacement_core_test.sv @@
// Self-checking testbench for ship_drrip_replacement_core: it drives cache accesses and
// checks chosen way, miss flag and insertion RRPV against an internal replacement model.
// Depends on sdrrip_pkg, sdrrip_ifs and the core RTL.
module ship_drrip_replacement_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sdrrip_pkg::*;

  localparam int LINES          = NUM_SETS * NUM_WAYS;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 20;

  typedef struct {
    logic [SET_IN_W-1:0] set_index;
    logic                hit;
    logic [WAY_IN_W-1:0] hit_way;
    logic [PC_W-1:0]     pc;
    logic [BADDR_W-1:0]  block_addr;
    bit                  drain_first;
  } access_t;

  typedef struct {
    logic [WAY_IN_W-1:0] chosen_way;
    logic                was_miss;
    logic [INS_W-1:0]    insert_rrpv;
  } choice_t;

  logic clk;
  logic rst;

  sdrrip_req_if req ();
  sdrrip_rsp_if rsp ();

  ship_drrip_replacement_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  rrpv_t line_rrpv [LINES];
  sig_t  line_sig  [LINES];
  ctr_t  reuse_ctr [SIG_COUNT];
  sel_t  duel_sel;

  access_t access_queue[$];
  choice_t predicted_choices[$];
  sig_t    sig_pool[8];
  int      set_pool[12];

  int  errors;
  int  total_items;
  int  accepted_cnt;
  int  results_seen;
  int  idle_cycles;
  int  hit_cnt;
  int  miss_cnt;
  int  ins_cnt[4];
  int  sel_min;
  int  sel_max;
  bit  req_taken;
  int  burst_left;
  int  gap_left;
  int  hold_left;
  bit  hold_done;
  int  seg_left;
  int  stall_pct;

  task automatic apply_access(input access_t a, output choice_t c);
    set_t  s;
    int    base;
    int    phase;
    int    idx;
    int    vw;
    bit    srrip_lead;
    bit    brrip_lead;
    way_t  w;
    rrpv_t top;
    rrpv_t lift;
    rrpv_t ins;
    sig_t  sg;
    logic [PC_W-1:0] mix;
    s = set_t'(a.set_index % NUM_SETS);
    base = int'(s) * NUM_WAYS;
    phase = int'(s) % DUEL_PERIOD;
    srrip_lead = (phase == 0);
    brrip_lead = (phase == 1);
    if (a.hit) begin
      w = way_t'(a.hit_way % NUM_WAYS);
      idx = base + int'(w);
      line_rrpv[idx] = '0;
      sg = line_sig[idx];
      if (reuse_ctr[sg] != CTR_TOP) reuse_ctr[sg]++;
      c.chosen_way = w;
      c.was_miss = 1'b0;
      c.insert_rrpv = '0;
      hit_cnt++;
    end else begin
      top = '0;
      for (int i = 0; i < NUM_WAYS; i++)
        if (line_rrpv[base + i] > top) top = line_rrpv[base + i];
      lift = RRPV_TOP - top;
      for (int i = 0; i < NUM_WAYS; i++) line_rrpv[base + i] = line_rrpv[base + i] + lift;
      vw = -1;
      for (int i = 0; i < NUM_WAYS; i++)
        if (vw < 0 && line_rrpv[base + i] == RRPV_TOP) vw = i;
      if (vw < 0) vw = 0;
      idx = base + vw;
      if (srrip_lead && duel_sel != SEL_TOP) duel_sel++;
      else if (brrip_lead && duel_sel != '0) duel_sel--;
      sg = line_sig[idx];
      if (reuse_ctr[sg] != '0) reuse_ctr[sg]--;
      mix = (a.pc >> PC_SHIFT) ^ (a.block_addr >> ADDR_SHIFT);
      sg = mix[SIG_W-1:0];
      line_sig[idx] = sg;
      if (reuse_ctr[sg] > CTR_HALF) ins = '0;
      else if (srrip_lead) ins = RRPV_MID;
      else if (brrip_lead || duel_sel >= SEL_START)
        ins = (sg[BRRIP_BITS-1:0] == '0) ? rrpv_t'(0) : RRPV_TOP;
      else ins = RRPV_MID;
      line_rrpv[idx] = ins;
      c.chosen_way = WAY_IN_W'(vw);
      c.was_miss = 1'b1;
      c.insert_rrpv = ins;
      miss_cnt++;
      ins_cnt[ins]++;
      if (int'(duel_sel) < sel_min) sel_min = int'(duel_sel);
      if (int'(duel_sel) > sel_max) sel_max = int'(duel_sel);
    end
  endtask

  function automatic access_t raw_access(int set_i, bit is_hit, int way_i,
                                         logic [PC_W-1:0] pc, logic [BADDR_W-1:0] addr,
                                         bit drain);
    access_t a;
    a.set_index = SET_IN_W'(set_i);
    a.hit = is_hit;
    a.hit_way = WAY_IN_W'(way_i);
    a.pc = pc;
    a.block_addr = addr;
    a.drain_first = drain;
    return a;
  endfunction

  function automatic access_t shaped_access(int set_i, bit is_hit, int way_i, sig_t sg,
                                            bit drain);
    logic [PC_W-1:0]    pc;
    logic [BADDR_W-1:0] addr;
    pc = {$urandom, $urandom};
    addr = {$urandom, $urandom};
    addr[ADDR_SHIFT +: SIG_W] = sg ^ pc[PC_SHIFT +: SIG_W];
    return raw_access(set_i, is_hit, way_i, pc, addr, drain);
  endfunction

  function automatic sig_t pick_sig();
    if ($urandom_range(0, 99) < 80) return sig_pool[$urandom_range(0, 7)];
    return sig_t'($urandom);
  endfunction

  function automatic int pick_set();
    if ($urandom_range(0, 99) < 85) return set_pool[$urandom_range(0, 11)];
    return $urandom_range(0, 2047);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : stimulus
    int      lead;
    bit      drain;
    rst = 1'b1;
    req.valid = 1'b0;
    req.set_index = '0;
    req.hit = 1'b0;
    req.hit_way = '0;
    req.pc = '0;
    req.block_addr = '0;
    rsp.ready = 1'b0;
    errors = 0;
    accepted_cnt = 0;
    results_seen = 0;
    idle_cycles = 0;
    hit_cnt = 0;
    miss_cnt = 0;
    ins_cnt = '{0, 0, 0, 0};
    req_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    seg_left = 0;
    stall_pct = 0;
    for (int i = 0; i < LINES; i++) begin
      line_rrpv[i] = RRPV_MID;
      line_sig[i] = '0;
    end
    for (int i = 0; i < SIG_COUNT; i++) reuse_ctr[i] = CTR_START;
    duel_sel = SEL_START;
    sel_min = int'(SEL_START);
    sel_max = int'(SEL_START);

    sig_pool = '{14'h0000, 14'h0020, 14'h3FE0, 14'h1234, 14'h3FFF, 14'h0, 14'h0, 14'h0};
    for (int i = 5; i < 8; i++) sig_pool[i] = sig_t'($urandom);
    set_pool = '{0, 1, 64, 65, 2047, 2046, 0, 0, 0, 0, 0, 0};
    for (int i = 6; i < 12; i++) set_pool[i] = $urandom_range(2, 2047);

    // directed: field extremes, leaders and followers, aging, counter saturation
    access_queue.push_back(raw_access(0, 0, 0, '0, '0, 0));
    access_queue.push_back(raw_access(1, 0, 0, '1, '1, 0));
    access_queue.push_back(raw_access(2047, 0, 15, '1, '0, 0));
    access_queue.push_back(raw_access(2047, 1, 15, '1, '1, 0));
    access_queue.push_back(raw_access(0, 1, 0, '0, '0, 0));
    for (int i = 0; i < 4; i++) access_queue.push_back(shaped_access(5, 1, 3, 14'h0000, 0));
    for (int i = 0; i < 4; i++) access_queue.push_back(shaped_access(5, 0, 0, 14'h0000, 0));
    access_queue.push_back(shaped_access(64, 0, 0, 14'h1234, 0));
    access_queue.push_back(shaped_access(65, 0, 0, 14'h0020, 0));
    access_queue.push_back(shaped_access(65, 0, 0, 14'h3FFF, 0));
    for (int i = 0; i < 3; i++) access_queue.push_back(shaped_access(9, 0, 7, 14'h1234, 0));
    access_queue.push_back(shaped_access(9, 1, 0, 14'h0020, 0));
    access_queue.push_back(shaped_access(9, 1, 15, 14'h3FE0, 0));
    access_queue.push_back(shaped_access(130, 0, 0, 14'h3FE0, 0));
    access_queue.push_back(shaped_access(130, 0, 0, 14'h0001, 0));

    for (int i = 0; i < 300; i++) begin
      drain = (i == 0) || ($urandom_range(0, 99) == 0);
      access_queue.push_back(shaped_access(pick_set(), 1'($urandom_range(0, 1)),
                                           $urandom_range(0, 15), pick_sig(), drain));
    end

    // drive the selector down, then up
    for (int phase_up = 0; phase_up < 2; phase_up++) begin
      for (int i = 0; i < (phase_up ? 100 : 80); i++) begin
        drain = (i == 0);
        lead = 64 * $urandom_range(0, NUM_SETS / 64 - 1) + (phase_up ? 0 : 1);
        if ($urandom_range(0, 99) < (phase_up ? 85 : 80))
          access_queue.push_back(shaped_access(lead, 0, 0, pick_sig(), drain));
        else
          access_queue.push_back(shaped_access(pick_set(), 1'($urandom_range(0, 1)),
                                               $urandom_range(0, 15), pick_sig(), drain));
      end
    end
    total_items = access_queue.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (!(accepted_cnt == total_items && predicted_choices.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(negedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d of %0d accesses accepted, %0d results pending",
               $time, accepted_cnt, total_items, predicted_choices.size());
      errors++;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (predicted_choices.size() != 0) begin
        $display("%0t: %0d predicted results never arrived", $time, predicted_choices.size());
        errors += predicted_choices.size();
      end
    end
    $display("Covered %0d accesses: %0d hits, %0d misses; insert RRPV 0/1/2/3 = %0d/%0d/%0d/%0d",
             accepted_cnt, hit_cnt, miss_cnt, ins_cnt[0], ins_cnt[1], ins_cnt[2], ins_cnt[3]);
    $display("Duel selector ranged %0d..%0d; long receiver hold and drained phase starts seen",
             sel_min, sel_max);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin : observe
    access_t a;
    choice_t want;
    choice_t got;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (req.valid && req.ready) begin
        a.set_index = req.set_index;
        a.hit = req.hit;
        a.hit_way = req.hit_way;
        a.pc = req.pc;
        a.block_addr = req.block_addr;
        a.drain_first = 1'b0;
        apply_access(a, want);
        predicted_choices.push_back(want);
        accepted_cnt++;
        req_taken = 1'b1;
        idle_cycles = 0;
      end
      if (rsp.valid && rsp.ready) begin
        idle_cycles = 0;
        results_seen++;
        got.chosen_way = rsp.chosen_way;
        got.was_miss = rsp.was_miss;
        got.insert_rrpv = rsp.insert_rrpv;
        if (predicted_choices.size() == 0) begin
          $display("%0t: unexpected result way=%0d miss=%0d rrpv=%0d", $time,
                   got.chosen_way, got.was_miss, got.insert_rrpv);
          errors++;
        end else begin
          want = predicted_choices.pop_front();
          if (got.chosen_way !== want.chosen_way) begin
            $display("%0t: chosen_way expected %0d actual %0d", $time,
                     want.chosen_way, got.chosen_way);
            errors++;
          end
          if (got.was_miss !== want.was_miss) begin
            $display("%0t: was_miss expected %0d actual %0d", $time,
                     want.was_miss, got.was_miss);
            errors++;
          end
          if (got.insert_rrpv !== want.insert_rrpv) begin
            $display("%0t: insert_rrpv expected %0d actual %0d", $time,
                     want.insert_rrpv, got.insert_rrpv);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : drive
    access_t nxt;
    logic    v;
    v = req.valid;
    if (rst) begin
      v = 1'b0;
    end else begin
      if (req_taken) begin
        v = 1'b0;
        req_taken = 1'b0;
      end
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_queue.size() > 0 &&
                     !(access_queue[0].drain_first && predicted_choices.size() > 0)) begin
          nxt = access_queue.pop_front();
          req.set_index <= nxt.set_index;
          req.hit <= nxt.hit;
          req.hit_way <= nxt.hit_way;
          req.pc <= nxt.pc;
          req.block_addr <= nxt.block_addr;
          v = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
    req.valid <= v;
  end

  always @(negedge clk) begin : receive
    logic r;
    if (rst) begin
      r = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      r = 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      r = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 120);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 30;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      r = ($urandom_range(0, 99) >= stall_pct);
    end
    rsp.ready <= r;
  end

endmodule
